// ===== rtl/crtm_pkg.sv =====
// ----------------------------------------------------------------------------
// crtm_pkg
// Shared constants and types of the CIDR range table match core.
// ----------------------------------------------------------------------------
package crtm_pkg;

    localparam int MAX_RANGES = 64;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [1:0] FAM_V4    = 2'd1;
    localparam logic [1:0] FAM_V6    = 2'd2;

    localparam logic [63:0] V4_BITS  = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic        en;
        logic [1:0]  family;
        logic [63:0] base_high;
        logic [63:0] base_low;
        logic [63:0] mask_high;
        logic [63:0] mask_low;
    } t_wr;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_query;

    typedef struct packed {
        logic vld;
        logic hit;
    } t_link;

endpackage

// ===== rtl/crtm_cell.sv =====
// ----------------------------------------------------------------------------
// crtm_cell
// One table slot: holds family, base and mask, checks the broadcast query
// when the search token reaches it and passes the token and hit flag on.
// ----------------------------------------------------------------------------
module crtm_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crtm_pkg::t_wr    i_wr,
    input  logic             i_wr_sel,
    input  crtm_pkg::t_query i_query,
    input  logic             i_in_use,
    input  crtm_pkg::t_link  i_link,
    output crtm_pkg::t_link  o_link
);

    logic [1:0]      r_family;
    logic [63:0]     r_base_high;
    logic [63:0]     r_base_low;
    logic [63:0]     r_mask_high;
    logic [63:0]     r_mask_low;
    crtm_pkg::t_link r_link;
    crtm_pkg::t_link n_link;
    logic            w_v4_eq;
    logic            w_v6_eq;
    logic            w_match;

    always_comb begin
        w_v4_eq = (((i_query.addr_low ^ r_base_low) & r_mask_low & crtm_pkg::V4_BITS)
                   == 64'd0);
        w_v6_eq = (((i_query.addr_low ^ r_base_low) & r_mask_low) == 64'd0) &&
                  (((i_query.addr_high ^ r_base_high) & r_mask_high) == 64'd0);
        w_match = 1'b0;
        if (r_family == i_query.kind) begin
            if (r_family == crtm_pkg::FAM_V4) begin
                w_match = w_v4_eq;
            end else if (r_family == crtm_pkg::FAM_V6) begin
                w_match = w_v6_eq;
            end
        end
        n_link.vld = i_link.vld;
        n_link.hit = i_link.hit | (i_link.vld & i_in_use & w_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= 2'd0;
            r_link   <= '0;
        end else begin
            r_link <= n_link;
            if (i_wr.en && i_wr_sel) begin
                r_family <= i_wr.family;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr_sel) begin
            r_base_high <= i_wr.base_high;
            r_base_low  <= i_wr.base_low;
            r_mask_high <= i_wr.mask_high;
            r_mask_low  <= i_wr.mask_low;
        end
    end

    assign o_link = r_link;

endmodule

// ===== rtl/cidr_range_table_match_core.sv =====
// ----------------------------------------------------------------------------
// cidr_range_table_match_core
// Table of IPv4 / IPv6 CIDR ranges searched by address queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries write and query items. A write
//   item loads one slot and completes at its transfer. A query item starts a
//   search token that walks the row of slot cells, one cell per cycle.
//   Output channel (o_valid / i_ready) carries one match flag per query.
//   A query's flag passes from the start register through the cell row and
//   the pending register into the output register. No new item is taken
//   while a query is in flight: o_ready returns high once its flag moves
//   into the output register, so writes wait until no query is in the row.
//   The ranges_in_use register (i_cfg_we / i_cfg_wdata) sets how many leading
//   slots take part; values above MAX_RANGES search all slots.
//   Reset clears all slot families to empty, the register to zero and all
//   control state. When the receiver stalls, the flag holds in the output
//   register, a second finished flag holds in a pending stage, and o_ready
//   stays low until that stage drains.
// ----------------------------------------------------------------------------
module cidr_range_table_match_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [5:0]  i_entry_index,
    input  logic [1:0]  i_entry_family,
    input  logic [1:0]  i_query_kind,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [63:0] i_mask_high,
    input  logic [63:0] i_mask_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_matched
);

    localparam int N = crtm_pkg::MAX_RANGES;

    logic [6:0]       r_ranges;
    logic             r_busy;
    logic             r_start;
    logic             r_pend_vld;
    logic             r_pend_hit;
    logic             r_out_vld;
    logic             r_out_hit;
    crtm_pkg::t_query r_query;
    crtm_pkg::t_wr    w_wr;
    crtm_pkg::t_link  w_link [N+1];
    logic [N-1:0]     w_tok;
    logic             w_in_fire;
    logic             w_q_fire;
    logic             w_move;
    logic [31:0]      w_idx32;
    logic [31:0]      w_ranges32;

    assign o_ready    = !r_busy;
    assign w_in_fire  = i_valid && o_ready;
    assign w_q_fire   = w_in_fire && (i_action == crtm_pkg::ACT_QUERY);
    assign w_move     = r_pend_vld && (!r_out_vld || i_ready);
    assign w_idx32    = 32'(i_entry_index);
    assign w_ranges32 = 32'(r_ranges);

    always_comb begin
        w_wr.en        = w_in_fire && (i_action == crtm_pkg::ACT_WRITE);
        w_wr.family    = i_entry_family;
        w_wr.base_high = i_addr_high;
        w_wr.base_low  = i_addr_low;
        w_wr.mask_high = i_mask_high;
        w_wr.mask_low  = i_mask_low;
        w_link[0].vld  = r_start;
        w_link[0].hit  = 1'b0;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        crtm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (w_wr),
            .i_wr_sel (w_idx32 == 32'(g)),
            .i_query  (r_query),
            .i_in_use (w_ranges32 > 32'(g)),
            .i_link   (w_link[g]),
            .o_link   (w_link[g+1])
        );
        assign w_tok[g] = w_link[g+1].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranges   <= 7'd0;
            r_busy     <= 1'b0;
            r_start    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ranges <= i_cfg_wdata;
            end
            r_start <= w_q_fire;
            if (w_q_fire) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_link[N].vld) begin
                r_pend_vld <= 1'b1;
            end else if (w_move) begin
                r_pend_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_fire) begin
            r_query.kind      <= i_query_kind;
            r_query.addr_high <= i_addr_high;
            r_query.addr_low  <= i_addr_low;
        end
        if (w_link[N].vld) begin
            r_pend_hit <= w_link[N].hit;
        end
        if (w_move) begin
            r_out_hit <= r_pend_hit;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_matched = r_out_hit;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok, r_start, r_pend_vld}))
        else $error("more than one search in flight");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_tok == '0) && !r_start && !r_pend_vld)
        else $error("search token present while idle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_fire |=> r_busy && r_start)
        else $error("query transfer did not start a search");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[N].vld |-> !r_pend_vld)
        else $error("pending result overwritten");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the CIDR range table match core. Slot writes and address
// queries are driven over the valid/ready input channel with random gaps,
// while the output side stalls at random. A scoreboard keeps its own copy of
// the range table and of ranges_in_use and predicts one match flag for each
// query. Every flag that arrives is checked in order against that prediction.
// A directed part covers the corner cases; random phases then run under
// several ranges_in_use settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] FAM_EMPTY  = 2'd0;
    localparam logic [1:0] FAM_BAD    = 2'd3;
    localparam logic [1:0] KIND_NONIP = 2'd0;
    localparam logic [1:0] KIND_BAD   = 2'd3;
    localparam int         SETTLE     = crtm_pkg::MAX_RANGES + 10;
    localparam int         WD_LIMIT   = 2000;
    localparam int         PHASES     = 8;
    localparam int         PHASE_LEN  = 250;

    typedef struct {
        logic        action;
        logic [5:0]  idx;
        logic [1:0]  fam;
        logic [1:0]  kind;
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] mh;
        logic [63:0] ml;
    } t_item;

    class match_scoreboard;
        logic [1:0]  fam_tbl [crtm_pkg::MAX_RANGES];
        logic [63:0] base_hi [crtm_pkg::MAX_RANGES];
        logic [63:0] base_lo [crtm_pkg::MAX_RANGES];
        logic [63:0] mask_hi [crtm_pkg::MAX_RANGES];
        logic [63:0] mask_lo [crtm_pkg::MAX_RANGES];
        logic [6:0]  ranges;
        bit          flag_q [$];
        int          errors;

        function new();
            for (int s = 0; s < crtm_pkg::MAX_RANGES; s++) begin
                fam_tbl[s] = FAM_EMPTY;
                base_hi[s] = '0;
                base_lo[s] = '0;
                mask_hi[s] = '0;
                mask_lo[s] = '0;
            end
            ranges = '0;
            errors = 0;
        endfunction

        function void set_ranges(logic [6:0] v);
            ranges = v;
        endfunction

        function bit lookup(logic [1:0] kind, logic [63:0] ah, logic [63:0] al);
            int n;
            bit hit;
            hit = 1'b0;
            n = (ranges > crtm_pkg::MAX_RANGES) ? crtm_pkg::MAX_RANGES : int'(ranges);
            if (kind == crtm_pkg::FAM_V4 || kind == crtm_pkg::FAM_V6) begin
                for (int s = 0; s < n; s++) begin
                    if (fam_tbl[s] == crtm_pkg::FAM_V4 && kind == crtm_pkg::FAM_V4 &&
                        ((al ^ base_lo[s]) & mask_lo[s] & crtm_pkg::V4_BITS) == 64'd0)
                        hit = 1'b1;
                    if (fam_tbl[s] == crtm_pkg::FAM_V6 && kind == crtm_pkg::FAM_V6 &&
                        ((al ^ base_lo[s]) & mask_lo[s]) == 64'd0 &&
                        ((ah ^ base_hi[s]) & mask_hi[s]) == 64'd0)
                        hit = 1'b1;
                end
            end
            return hit;
        endfunction

        function void note_input(t_item it);
            if (it.action == crtm_pkg::ACT_WRITE) begin
                if (int'(it.idx) < crtm_pkg::MAX_RANGES) begin
                    fam_tbl[it.idx] = it.fam;
                    base_hi[it.idx] = it.ah;
                    base_lo[it.idx] = it.al;
                    mask_hi[it.idx] = it.mh;
                    mask_lo[it.idx] = it.ml;
                end
            end else begin
                flag_q.push_back(lookup(it.kind, it.ah, it.al));
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic got);
            bit want;
            if (flag_q.size() == 0) begin
                report($sformatf("result with no pending query, matched=%0b", got));
                return;
            end
            want = flag_q.pop_front();
            if (got !== want)
                report($sformatf("matched got %0b expected %0b", got, want));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [5:0]  i_entry_index;
    logic [1:0]  i_entry_family;
    logic [1:0]  i_query_kind;
    logic [63:0] i_addr_high;
    logic [63:0] i_addr_low;
    logic [63:0] i_mask_high;
    logic [63:0] i_mask_low;
    logic        o_valid;
    logic        i_ready;
    logic        o_matched;

    match_scoreboard sb;
    bit              tx_idle;
    bit              rx_idle;
    int              wd_count;

    cidr_range_table_match_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_entry_family (i_entry_family),
        .i_query_kind   (i_query_kind),
        .i_addr_high    (i_addr_high),
        .i_addr_low     (i_addr_low),
        .i_mask_high    (i_mask_high),
        .i_mask_low     (i_mask_low),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_matched      (o_matched)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [127:0] prefix_mask(int len, int span);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < len; b++)
            m[span-1-b] = 1'b1;
        return m;
    endfunction

    function automatic t_item mk_write(logic [5:0] idx, logic [1:0] fam, logic [63:0] ah,
                                       logic [63:0] al, logic [63:0] mh, logic [63:0] ml);
        t_item it;
        it.action = crtm_pkg::ACT_WRITE;
        it.idx    = idx;
        it.fam    = fam;
        it.kind   = KIND_NONIP;
        it.ah     = ah;
        it.al     = al;
        it.mh     = mh;
        it.ml     = ml;
        return it;
    endfunction

    function automatic t_item mk_query(logic [1:0] kind, logic [63:0] ah, logic [63:0] al);
        t_item it;
        it.action = crtm_pkg::ACT_QUERY;
        it.idx    = '0;
        it.fam    = FAM_EMPTY;
        it.kind   = kind;
        it.ah     = ah;
        it.al     = al;
        it.mh     = '0;
        it.ml     = '0;
        return it;
    endfunction

    // slots that take part are favored
    function automatic int pick_slot();
        int lim;
        lim = (sb.ranges > crtm_pkg::MAX_RANGES || sb.ranges == 0) ?
              crtm_pkg::MAX_RANGES : int'(sb.ranges);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, crtm_pkg::MAX_RANGES - 1);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic t_item rand_write();
        t_item        it;
        logic [127:0] m;
        int           sel;
        it.action = crtm_pkg::ACT_WRITE;
        it.idx    = 6'(pick_slot());
        it.kind   = 2'($urandom_range(0, 3));
        it.ah     = rand64();
        it.al     = rand64();
        sel = $urandom_range(0, 19);
        if (sel < 9)
            it.fam = crtm_pkg::FAM_V4;
        else if (sel < 18)
            it.fam = crtm_pkg::FAM_V6;
        else
            it.fam = (sel == 18) ? FAM_EMPTY : FAM_BAD;
        if ($urandom_range(0, 4) == 0)
            m = {rand64(), rand64()};
        else if (it.fam == crtm_pkg::FAM_V4)
            m = {rand64(), rand64()} & ~prefix_mask(32, 32) |
                prefix_mask($urandom_range(0, 32), 32);
        else
            m = prefix_mask($urandom_range(0, 128), 128);
        it.mh = m[127:64];
        it.ml = m[63:0];
        return it;
    endfunction

    function automatic t_item rand_query();
        t_item        it;
        logic [127:0] b;
        logic [127:0] m;
        logic [127:0] a;
        int           s;
        int           sel;
        it.action = crtm_pkg::ACT_QUERY;
        it.idx    = 6'($urandom_range(0, 63));
        it.fam    = 2'($urandom_range(0, 3));
        it.mh     = rand64();
        it.ml     = rand64();
        a   = {rand64(), rand64()};
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            s = pick_slot();
            b = {sb.base_hi[s], sb.base_lo[s]};
            m = {sb.mask_hi[s], sb.mask_lo[s]};
            a = (b & m) | (a & ~m);
            if (sel == 6)
                a[$urandom_range(0, 127)] ^= 1'b1;
            it.kind = sb.fam_tbl[s];
        end else begin
            it.kind = 2'($urandom_range(0, 3));
        end
        it.ah = a[127:64];
        it.al = a[63:0];
        return it;
    endfunction

    // starts and returns at a falling edge; valid stays high for a back-to-back item
    task automatic send_item(input t_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action       = it.action;
        i_entry_index  = it.idx;
        i_entry_family = it.fam;
        i_query_kind   = it.kind;
        i_addr_high    = it.ah;
        i_addr_low     = it.al;
        i_mask_high    = it.mh;
        i_mask_low     = it.ml;
        i_valid        = 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        i_valid = 1'b0;
        while (sb.flag_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_ranges(input logic [6:0] v);
        drain_all();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_ranges(v);
    endtask

    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            sb.check_result(o_matched);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [6:0] cfg_val;
        sb             = new();
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        wd_count       = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_action       = crtm_pkg::ACT_WRITE;
        i_entry_index  = '0;
        i_entry_family = FAM_EMPTY;
        i_query_kind   = KIND_NONIP;
        i_addr_high    = '0;
        i_addr_low     = '0;
        i_mask_high    = '0;
        i_mask_low     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting searches no slot
        send_item(mk_write(6'd0, crtm_pkg::FAM_V4, '1, 64'hFFFF_FFFF_0A00_0000, '0,
                           64'h0000_0000_FFFF_FF00));
        send_item(mk_write(6'd63, crtm_pkg::FAM_V6, '1, '1, '1, '1));
        send_item(mk_query(crtm_pkg::FAM_V4, '0, 64'h0000_0000_0A00_0005));

        write_ranges(7'd64);
        send_item(mk_query(crtm_pkg::FAM_V4, '0, 64'h0000_0000_0A00_0005));
        send_item(mk_query(crtm_pkg::FAM_V4, '0, 64'h0000_0000_0A00_0105));
        send_item(mk_query(crtm_pkg::FAM_V4, '1, 64'hFFFF_FFFF_0A00_00FF));
        send_item(mk_query(crtm_pkg::FAM_V6, '1, '1));
        send_item(mk_query(crtm_pkg::FAM_V6, '1, 64'hFFFF_FFFF_FFFF_FFFE));
        send_item(mk_query(KIND_NONIP, '1, '1));
        send_item(mk_query(KIND_BAD, '0, 64'h0000_0000_0A00_0005));
        send_item(mk_write(6'd5, FAM_BAD, '0, '0, '0, '0));
        send_item(mk_query(crtm_pkg::FAM_V4, '0, 64'h0000_0000_1234_5678));
        send_item(mk_query(crtm_pkg::FAM_V6, '0, '0));

        write_ranges(7'd127);
        send_item(mk_query(crtm_pkg::FAM_V6, '1, '1));

        write_ranges(7'd63);
        send_item(mk_query(crtm_pkg::FAM_V6, '1, '1));
        send_item(mk_query(crtm_pkg::FAM_V4, '1, 64'h0000_0000_0A00_0005));

        write_ranges(7'd1);
        send_item(mk_write(6'd1, crtm_pkg::FAM_V6, '0, '0, '0, '0));
        send_item(mk_query(crtm_pkg::FAM_V6, rand64(), rand64()));

        write_ranges(7'd2);
        send_item(mk_query(crtm_pkg::FAM_V6, rand64(), rand64()));
        send_item(mk_query(crtm_pkg::FAM_V4, '0, 64'h0000_0000_0B00_0000));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: cfg_val = 7'd64;
                1: cfg_val = 7'd127;
                2: cfg_val = 7'd0;
                3: cfg_val = 7'd1;
                4: cfg_val = 7'($urandom_range(65, 127));
                default: cfg_val = 7'($urandom_range(2, 64));
            endcase
            write_ranges(cfg_val);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (k % 25 == 0) begin
                    tx_idle = ($urandom_range(0, 3) != 0);
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 1) == 0)
                    send_item(rand_write());
                else
                    send_item(rand_query());
            end
        end

        drain_all();
        if (sb.flag_q.size() != 0)
            sb.report("queries left without a result");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
